### rtl/core/sxd_pkg.sv
// ----------------------------------------------------------------------------
// sxd_pkg
// shared types, opcode table and lookup for the instruction field decoder
// ----------------------------------------------------------------------------
package sxd_pkg;

  localparam int unsigned OPS_COUNT = 59;
  localparam logic [5:0]  IDX_LDB   = 6'd20;
  localparam logic [5:0]  IDX_LDX   = 6'd26;

  // instruction class from the opcode table
  typedef enum logic [1:0] {
    CLS_F1  = 2'd1,
    CLS_F2  = 2'd2,
    CLS_F34 = 2'd3
  } sxd_cls_e;

  // addressing mode codes
  typedef enum logic [1:0] {
    MODE_SIMPLE    = 2'd0,
    MODE_IMMEDIATE = 2'd1,
    MODE_INDIRECT  = 2'd2,
    MODE_INVALID   = 2'd3
  } sxd_mode_e;

  localparam logic [7:0] OP_BYTES [OPS_COUNT] = '{
    8'h18, 8'h58, 8'h90, 8'h40, 8'hB4, 8'h28,
    8'h88, 8'hA0, 8'h24, 8'h64, 8'h9C, 8'hC4,
    8'hC0, 8'hF4, 8'h3C, 8'h30, 8'h34, 8'h38,
    8'h48, 8'h00, 8'h68, 8'h50, 8'h70, 8'h08,
    8'h6C, 8'h74, 8'h04, 8'hD0, 8'h20, 8'h60,
    8'h98, 8'hC8, 8'h44, 8'hD8, 8'hAC, 8'h4C,
    8'hA4, 8'hA8, 8'hF0, 8'hEC, 8'h0C, 8'h78,
    8'h54, 8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8,
    8'h84, 8'h10, 8'h1C, 8'h5C, 8'h94, 8'hB0,
    8'hE0, 8'hF8, 8'h2C, 8'hB8, 8'hDC
  };

  localparam sxd_cls_e OP_CLASS [OPS_COUNT] = '{
    CLS_F34, CLS_F34, CLS_F2,  CLS_F34, CLS_F2,  CLS_F34,
    CLS_F34, CLS_F2,  CLS_F34, CLS_F34, CLS_F2,  CLS_F1,
    CLS_F1,  CLS_F1,  CLS_F34, CLS_F34, CLS_F34, CLS_F34,
    CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F34,
    CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F34,
    CLS_F2,  CLS_F1,  CLS_F34, CLS_F34, CLS_F2,  CLS_F34,
    CLS_F2,  CLS_F2,  CLS_F1,  CLS_F34, CLS_F34, CLS_F34,
    CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F34,
    CLS_F34, CLS_F34, CLS_F34, CLS_F34, CLS_F2,  CLS_F2,
    CLS_F34, CLS_F1,  CLS_F34, CLS_F2,  CLS_F34
  };

  typedef struct packed {
    logic [7:0]  obj_byte;
    logic        record_start;
    logic [19:0] record_addr;
  } sxd_in_t;

  typedef struct packed {
    logic [19:0] instr_addr;
    logic [5:0]  opcode;
    logic [5:0]  mnemonic_index;
    logic        known_opcode;
    logic [2:0]  instr_format;
    logic [5:0]  nixbpe;
    logic [1:0]  addr_mode;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic [19:0] target;
  } sxd_res_t;

  // table lookup result
  typedef struct packed {
    logic [5:0] idx;
    logic       known;
    sxd_cls_e   cls;
  } sxd_op_t;

  // a collected instruction as handed from front to back
  typedef struct packed {
    logic [3:0][7:0] ins_bytes;
    logic [2:0]      fmt;
    sxd_op_t         op;
  } sxd_instr_t;

  // unknown opcodes fall back to format 3/4 with index zero
  function automatic sxd_op_t sxd_lookup(input logic [5:0] op6);
    sxd_op_t r;
    r.idx   = '0;
    r.known = 1'b0;
    r.cls   = CLS_F34;
    for (int k = OPS_COUNT - 1; k >= 0; k--) begin
      if (OP_BYTES[k][7:2] == op6) begin
        r.idx   = 6'(k);
        r.known = 1'b1;
        r.cls   = OP_CLASS[k];
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/sxd_fifo.sv
// ----------------------------------------------------------------------------
// sxd_fifo
// small register queue, push and pop in the same cycle even when full
// ----------------------------------------------------------------------------
module sxd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i & ~empty_o;
  assign do_push = push_i & (~full_o | do_pop);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/sxd_front.sv
// ----------------------------------------------------------------------------
// sxd_front
// byte collector: tracks the location counter and emits whole instructions
// ----------------------------------------------------------------------------
module sxd_front #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  sxd_pkg::sxd_in_t       item_i,
  input  logic                   room_i,
  output logic                   push_o,
  output logic [ADDR_BITS-1:0]   addr_o,
  output sxd_pkg::sxd_instr_t    instr_o
);

  import sxd_pkg::*;

  logic [3:0][7:0]       buf_q, buf_d, bytes_cur;
  logic [2:0]            held_q, held_d, held_eff, held_new;
  logic [ADDR_BITS-1:0]  lc_q, lc_d, lc_eff;
  logic [ADDR_BITS+19:0] rec_addr_ext;
  logic                  accept, complete;
  logic [2:0]            need;
  sxd_op_t               op;

  assign accept       = valid_i & room_i;
  assign rec_addr_ext = {{ADDR_BITS{1'b0}}, item_i.record_addr};

  always_comb begin
    held_eff = item_i.record_start ? 3'd0 : held_q;
    lc_eff   = item_i.record_start ? rec_addr_ext[ADDR_BITS-1:0] : lc_q;
    held_new = held_eff + 3'd1;

    bytes_cur                = buf_q;
    bytes_cur[held_eff[1:0]] = item_i.obj_byte;

    op       = sxd_lookup(bytes_cur[0][7:2]);
    need     = 3'd3;
    complete = 1'b0;
    unique case (op.cls)
      CLS_F1: begin
        need     = 3'd1;
        complete = 1'b1;
      end
      CLS_F2: begin
        need     = 3'd2;
        complete = (held_new >= 3'd2);
      end
      default: begin
        need     = bytes_cur[1][4] ? 3'd4 : 3'd3;
        complete = (held_new >= need);
      end
    endcase

    buf_d  = buf_q;
    held_d = held_q;
    lc_d   = lc_q;
    if (accept) begin
      if (complete) begin
        held_d = '0;
        lc_d   = lc_eff + ADDR_BITS'(need);
      end else begin
        buf_d  = bytes_cur;
        held_d = held_new;
        lc_d   = lc_eff;
      end
    end
  end

  assign push_o            = accept & complete;
  assign addr_o            = lc_eff;
  assign instr_o.ins_bytes = bytes_cur;
  assign instr_o.fmt       = need;
  assign instr_o.op        = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
      lc_q   <= '0;
    end else begin
      buf_q  <= buf_d;
      held_q <= held_d;
      lc_q   <= lc_d;
    end
  end

endmodule

### rtl/core/sxd_back.sv
// ----------------------------------------------------------------------------
// sxd_back
// field extraction, target address arithmetic and base and index tracking
// ----------------------------------------------------------------------------
module sxd_back #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  sxd_pkg::sxd_instr_t  instr_i,
  input  logic                 room_i,
  output logic                 take_o,
  output sxd_pkg::sxd_res_t    res_o
);

  import sxd_pkg::*;

  logic [ADDR_BITS-1:0]  base_q, base_d, index_q, index_d;
  logic [ADDR_BITS-1:0]  tgt, tgt_pre, disp_s, disp_u;
  logic [ADDR_BITS+19:0] far_ext, addr_ext, tgt_ext;
  logic [7:0]            b0, b1, b2, b3;
  logic [11:0]           disp;
  logic [1:0]            ni;
  logic                  fx, fb, fp, fe;
  sxd_mode_e             mode;

  assign take_o = valid_i & room_i;

  always_comb begin
    b0 = instr_i.ins_bytes[0];
    b1 = instr_i.ins_bytes[1];
    b2 = instr_i.ins_bytes[2];
    b3 = instr_i.ins_bytes[3];
    ni = b0[1:0];
    {fx, fb, fp, fe} = b1[7:4];
    disp    = {b1[3:0], b2};
    disp_s  = {{(ADDR_BITS-12){disp[11]}}, disp};
    disp_u  = {{(ADDR_BITS-12){1'b0}}, disp};
    far_ext = {{ADDR_BITS{1'b0}}, b1[3:0], b2, b3};

    unique case (ni)
      2'd3:    mode = MODE_SIMPLE;
      2'd1:    mode = MODE_IMMEDIATE;
      2'd2:    mode = MODE_INDIRECT;
      default: mode = MODE_INVALID;
    endcase
    if ((fx && ni != 2'd3) || (fb && fp) || (fe && (fb || fp))) begin
      mode = MODE_INVALID;
    end

    // pc-relative wins over base-relative when both are set
    priority if (fe) begin
      tgt_pre = far_ext[ADDR_BITS-1:0];
    end else if (fp) begin
      tgt_pre = addr_i + ADDR_BITS'(3) + disp_s;
    end else if (fb) begin
      tgt_pre = base_q + disp_u;
    end else begin
      tgt_pre = disp_u;
    end
    tgt = fx ? tgt_pre + index_q : tgt_pre;

    base_d  = base_q;
    index_d = index_q;
    if (take_o && instr_i.op.cls == CLS_F34 && instr_i.op.known) begin
      if (instr_i.op.idx == IDX_LDB && mode != MODE_INVALID) begin
        base_d = tgt;
      end
      if (instr_i.op.idx == IDX_LDX && mode == MODE_IMMEDIATE) begin
        index_d = tgt;
      end
    end

    addr_ext = {20'd0, addr_i};
    tgt_ext  = {20'd0, tgt};

    res_o.instr_addr     = addr_ext[19:0];
    res_o.opcode         = b0[7:2];
    res_o.mnemonic_index = instr_i.op.known ? instr_i.op.idx : 6'd0;
    res_o.known_opcode   = instr_i.op.known;
    res_o.instr_format   = instr_i.fmt;
    res_o.nixbpe         = '0;
    res_o.addr_mode      = MODE_SIMPLE;
    res_o.reg_first      = '0;
    res_o.reg_second     = '0;
    res_o.target         = '0;
    unique case (instr_i.op.cls)
      CLS_F2: begin
        res_o.reg_first  = b1[7:4];
        res_o.reg_second = b1[3:0];
      end
      CLS_F34: begin
        res_o.nixbpe    = {ni, b1[7:4]};
        res_o.addr_mode = mode;
        res_o.target    = tgt_ext[19:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      index_q <= '0;
    end else begin
      base_q  <= base_d;
      index_q <= index_d;
    end
  end

endmodule

### rtl/core/sicxe_instruction_field_decoder.sv
// ----------------------------------------------------------------------------
// sicxe_instruction_field_decoder
// decodes a byte stream of object code into one item per instruction
// ----------------------------------------------------------------------------
// Object code bytes go in one per cycle while full is low, with no gaps
// needed; an item with record_start set reloads the location counter from
// record_addr and drops any half-collected instruction. Each complete
// instruction (format 1, 2, 3 or 4) comes out as one result item with
// address, opcode, table index, flags, addressing mode, registers and
// target. The block sustains one byte per cycle while full is low, and so
// at most one result per cycle; a result passes a two-entry queue between
// the collector and the decode stage and then a two-entry result queue.
// full rises when the inner queue holds two waiting instructions, which
// only happens while pop is held off. Base and index values from LDB and
// immediate LDX apply from the very next instruction on.
module sicxe_instruction_field_decoder #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sxd_pkg::sxd_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output sxd_pkg::sxd_res_t res_item_o
);

  import sxd_pkg::*;

  localparam int unsigned MID_W = ADDR_BITS + $bits(sxd_instr_t);

  // front to queue
  logic                 fr_push;
  logic [ADDR_BITS-1:0] fr_addr;
  sxd_instr_t           fr_instr;

  // queue to back
  logic                 mid_full, mid_empty;
  logic [MID_W-1:0]     mid_data;
  logic [ADDR_BITS-1:0] bk_addr;
  sxd_instr_t           bk_instr;

  // back to result queue
  logic                 bk_take, out_full, out_room;
  sxd_res_t             bk_res;

  assign full                = mid_full;
  assign {bk_addr, bk_instr} = mid_data;
  // a slot frees in the same cycle when the head item is being taken
  assign out_room            = ~out_full | (pop & ~empty);

  sxd_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (push),
    .item_i  (in_item_i),
    .room_i  (~mid_full),
    .push_o  (fr_push),
    .addr_o  (fr_addr),
    .instr_o (fr_instr)
  );

  // collected instructions waiting for decode
  sxd_fifo #(
    .WIDTH (MID_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  ({fr_addr, fr_instr}),
    .full_o  (mid_full),
    .pop_i   (bk_take),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  sxd_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (~mid_empty),
    .addr_i  (bk_addr),
    .instr_i (bk_instr),
    .room_i  (out_room),
    .take_o  (bk_take),
    .res_o   (bk_res)
  );

  // decoded items waiting to be popped
  sxd_fifo #(
    .WIDTH ($bits(sxd_res_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_take),
    .data_i  (bk_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_item_o),
    .empty_o (empty)
  );

endmodule

### rtl/core/sxd_checker.sv
// ----------------------------------------------------------------------------
// sxd_checker
// port-level checks on the instruction field decoder
// ----------------------------------------------------------------------------
module sxd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input sxd_pkg::sxd_res_t res_item_o
);

  import sxd_pkg::*;

  // a waiting item stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_item_o)))
    else $error("result item changed before pop");

  a_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_item_o.instr_format != 3'd0 && res_item_o.instr_format <= 3'd4))
    else $error("instruction format out of range");

  // formats 1 and 2 carry no flags or target
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_item_o.instr_format <= 3'd2) |->
      (res_item_o.nixbpe == 6'd0 && res_item_o.target == 20'd0))
    else $error("short format with flags or target");

  // unknown opcodes decode as format 3 or 4 with index zero
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_item_o.known_opcode) |->
      (res_item_o.mnemonic_index == 6'd0 &&
       (res_item_o.instr_format == 3'd3 || res_item_o.instr_format == 3'd4)))
    else $error("unknown opcode decoded wrongly");

  // with n and i both clear the mode must read invalid
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_item_o.instr_format >= 3'd3 && res_item_o.nixbpe[5:4] == 2'b00) |->
      (res_item_o.addr_mode == MODE_INVALID))
    else $error("missing invalid addressing mode");

endmodule

bind sicxe_instruction_field_decoder sxd_checker u_sxd_checker (.*);
